[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros shared by the RTL of the hash table unit.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CHK_IMPL(lbl, clk, rst_n, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CHK_NEXT(lbl, clk, rst_n, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

[rtl/lpht_pkg.sv]
// ----------------------------------------------------------------------------
// lpht_pkg
// Types and constants of the linear probing hash table unit.
// ----------------------------------------------------------------------------
package lpht_pkg;

	localparam int SLOTS_DEF     = 16;
	localparam int KEY_BYTES_DEF = 8;

	localparam int KEY_W      = 64;
	localparam int LANE_N     = KEY_W / 8;
	localparam int HANDLE_W   = 32;
	localparam int COUNT_W    = 16;
	localparam int SLOT_OUT_W = 4;
	localparam int FILL_OUT_W = 5;

	typedef enum logic {
		CMD_INSERT = 1'b0,
		CMD_LOOKUP = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		ST_INSERTED = 2'd0,
		ST_FOUND    = 2'd1,
		ST_MISSING  = 2'd2,
		ST_FULL     = 2'd3
	} status_t;

	typedef struct packed {
		cmd_t                cmd;
		logic [KEY_W-1:0]    key_bytes;
		logic [HANDLE_W-1:0] value_handle;
		logic [COUNT_W-1:0]  token_count;
	} req_t;

	typedef struct packed {
		status_t               status;
		logic [HANDLE_W-1:0]   found_handle;
		logic [COUNT_W-1:0]    found_count;
		logic [SLOT_OUT_W-1:0] slot_index;
		logic [FILL_OUT_W-1:0] fill_count;
	} rsp_t;

	// Contents of one occupied slot.
	typedef struct packed {
		logic [KEY_W-1:0]    key;
		logic [HANDLE_W-1:0] handle;
		logic [COUNT_W-1:0]  count;
	} entry_t;

endpackage

[rtl/lpht_key_lanes.sv]
// ----------------------------------------------------------------------------
// lpht_key_lanes
// One lane per key byte finds whether the byte is still part of the key; a
// merge stage assembles the trimmed key and the byte sum used as hash.
// ----------------------------------------------------------------------------
module lpht_key_lanes import lpht_pkg::*; #(
	parameter int KEY_BYTES = KEY_BYTES_DEF,
	localparam int SUM_W = $clog2(KEY_BYTES * 255 + 1)
) (
	input  logic [KEY_W-1:0] raw_key,
	output logic [KEY_W-1:0] trim_key,
	output logic [SUM_W-1:0] byte_sum
);

	logic [LANE_N-1:0] byte_nz;
	logic [LANE_N-1:0] alive;

	// Each lane tests its own byte against zero and against the key length.
	for (genvar lane = 0; lane < LANE_N; lane++) begin : g_lane
		assign byte_nz[lane] = (lane < KEY_BYTES) && (raw_key[8*lane +: 8] != 8'd0);
	end

	// A byte is kept only while every lower byte was kept as well.
	always_comb begin
		alive[0] = byte_nz[0];
		for (int i = 1; i < LANE_N; i++) begin
			alive[i] = alive[i-1] & byte_nz[i];
		end
	end

	always_comb begin
		trim_key = '0;
		byte_sum = '0;
		for (int i = 0; i < LANE_N; i++) begin
			if (alive[i]) begin
				trim_key[8*i +: 8] = raw_key[8*i +: 8];
				byte_sum = byte_sum + SUM_W'(raw_key[8*i +: 8]);
			end
		end
	end

endmodule

[rtl/lpht_slot_mem.sv]
// ----------------------------------------------------------------------------
// lpht_slot_mem
// Slot storage: a one-bit occupancy memory and an entry memory, sharing one
// write port and one read port, with registered read data.
// ----------------------------------------------------------------------------
module lpht_slot_mem import lpht_pkg::*; #(
	parameter int SLOTS = SLOTS_DEF,
	localparam int IDX_W = $clog2(SLOTS)
) (
	input  logic             clk,
	input  logic             used_we,
	input  logic             data_we,
	input  logic [IDX_W-1:0] waddr,
	input  logic             wused,
	input  entry_t           wdata,
	input  logic [IDX_W-1:0] raddr,
	output logic             rd_used,
	output entry_t           rd_data
);

	logic   used_mem [SLOTS];
	entry_t data_mem [SLOTS];

	always_ff @(posedge clk) begin
		if (used_we) begin
			used_mem[waddr] <= wused;
		end
		if (data_we) begin
			data_mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rd_used <= used_mem[raddr];
		rd_data <= data_mem[raddr];
	end

endmodule

[rtl/linear_probe_hash_table_unit.sv]
// ----------------------------------------------------------------------------
// linear_probe_hash_table_unit
// Open addressing hash table with linear probing, insert and lookup commands.
// ----------------------------------------------------------------------------
// A command is taken on a rising edge with start high and busy low; req holds
// the operation, the key, and the handle and token count stored by an insert.
// Each command gives one result on rsp, valid for the single cycle in which
// done is high; the receiver cannot stall, so it must take rsp in that cycle.
// Timing: the home slot is the byte sum modulo the slot count. A multiply by a
// scaled reciprocal gives the quotient, which is registered, and a multiply and
// subtract gives the remainder in the next cycle. The probe then reads one slot
// per cycle from the slot memory, whose single read port sets the pace: the
// first read is issued, then each slot read back is examined in turn, up to
// SLOTS of them. done rises in the same cycle in which busy falls; the result
// is taken at the edge that ends it, where the next command may also be taken.
// After reset the unit sweeps the occupancy memory, one slot per cycle, with
// busy high until every slot is cleared; the table is then empty.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module linear_probe_hash_table_unit import lpht_pkg::*; #(
	parameter int SLOTS     = SLOTS_DEF,
	parameter int KEY_BYTES = KEY_BYTES_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  req_t req,
	output logic done,
	output rsp_t rsp
);

	localparam int IDX_W   = $clog2(SLOTS);
	localparam int OCC_W   = $clog2(SLOTS + 1);
	localparam int MAX_SUM = KEY_BYTES * 255;
	localparam int SUM_W   = $clog2(MAX_SUM + 1);
	// The reciprocal is rounded up and scaled far enough that the truncated
	// product is the exact quotient for every byte sum.
	localparam int RCP_SH  = SUM_W + IDX_W;
	localparam int RCP_W   = SUM_W + 2;
	localparam int PROD_W  = SUM_W + RCP_W;
	localparam int MUL_W   = SUM_W + IDX_W + 1;
	localparam logic [RCP_W-1:0] RCP = RCP_W'(((1 << RCP_SH) + SLOTS - 1) / SLOTS);

	typedef enum logic [1:0] {
		S_CLEAR,
		S_IDLE,
		S_MOD,
		S_PROBE
	} state_t;

	state_t              state_q;
	logic [IDX_W-1:0]    iss_q;
	logic [IDX_W-1:0]    chk_q;
	logic [IDX_W-1:0]    n_q;
	logic                first_q;
	logic                step_q;
	logic [SUM_W-1:0]    sum_q;
	logic [SUM_W-1:0]    quo_q;
	logic [OCC_W-1:0]    occupied_q;
	logic                done_q;
	rsp_t                rsp_q;

	cmd_t                cmd_q;
	logic [KEY_W-1:0]    key_q;
	logic [HANDLE_W-1:0] handle_q;
	logic [COUNT_W-1:0]  count_q;

	logic [KEY_W-1:0]    lane_key;
	logic [SUM_W-1:0]    lane_sum;

	logic                used_we;
	logic                data_we;
	logic [IDX_W-1:0]    waddr;
	logic                wused;
	entry_t              wdata;
	logic                rd_used;
	entry_t              rd_data;

	logic [PROD_W-1:0]   prod;
	logic [SUM_W-1:0]    quo_d;
	logic [MUL_W-1:0]    rem_full;
	logic [IDX_W-1:0]    home;
	logic                chk_valid;
	logic                stop_ins;
	logic                stop_hit;
	logic                last_slot;
	logic                finish;
	logic [OCC_W-1:0]    occ_next;
	logic [IDX_W+SLOT_OUT_W-1:0] slot_ext;
	logic [OCC_W+FILL_OUT_W-1:0] fill_ext;
	rsp_t                rsp_d;

	function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] x);
		return (x == IDX_W'(SLOTS - 1)) ? '0 : x + 1'b1;
	endfunction

	lpht_key_lanes #(
		.KEY_BYTES (KEY_BYTES)
	) u_lanes (
		.raw_key  (req.key_bytes),
		.trim_key (lane_key),
		.byte_sum (lane_sum)
	);

	lpht_slot_mem #(
		.SLOTS (SLOTS)
	) u_mem (
		.clk     (clk),
		.used_we (used_we),
		.data_we (data_we),
		.waddr   (waddr),
		.wused   (wused),
		.wdata   (wdata),
		.raddr   (iss_q),
		.rd_used (rd_used),
		.rd_data (rd_data)
	);

	// Quotient from the reciprocal product, remainder from the registered quotient.
	always_comb begin
		prod     = PROD_W'(sum_q) * PROD_W'(RCP);
		quo_d    = SUM_W'(prod >> RCP_SH);
		rem_full = MUL_W'(sum_q) - MUL_W'(quo_q) * MUL_W'(SLOTS);
		home     = rem_full[IDX_W-1:0];
	end

	// Read data always belongs to chk_q once the first issue cycle is past.
	always_comb begin
		chk_valid = (state_q == S_PROBE) && !first_q;
		stop_ins  = chk_valid && (cmd_q == CMD_INSERT) && !rd_used;
		stop_hit  = chk_valid && (cmd_q == CMD_LOOKUP) && rd_used && (rd_data.key == key_q);
		last_slot = n_q == IDX_W'(SLOTS - 1);
		finish    = chk_valid && (!rd_used || stop_hit || last_slot);
		occ_next  = stop_ins ? occupied_q + 1'b1 : occupied_q;
	end

	always_comb begin
		slot_ext = {{SLOT_OUT_W{1'b0}}, chk_q};
		fill_ext = {{FILL_OUT_W{1'b0}}, occ_next};
		rsp_d              = '0;
		rsp_d.fill_count   = fill_ext[FILL_OUT_W-1:0];
		priority if (stop_ins) begin
			rsp_d.status     = ST_INSERTED;
			rsp_d.slot_index = slot_ext[SLOT_OUT_W-1:0];
		end else if (stop_hit) begin
			rsp_d.status       = ST_FOUND;
			rsp_d.found_handle = rd_data.handle;
			rsp_d.found_count  = rd_data.count;
			rsp_d.slot_index   = slot_ext[SLOT_OUT_W-1:0];
		end else if (cmd_q == CMD_LOOKUP) begin
			rsp_d.status = ST_MISSING;
		end else begin
			rsp_d.status = ST_FULL;
		end
	end

	// The clearing sweep and an insert share the write port.
	always_comb begin
		wdata.key    = key_q;
		wdata.handle = handle_q;
		wdata.count  = count_q;
		if (state_q == S_CLEAR) begin
			used_we = 1'b1;
			data_we = 1'b0;
			waddr   = iss_q;
			wused   = 1'b0;
		end else begin
			used_we = stop_ins;
			data_we = stop_ins;
			waddr   = chk_q;
			wused   = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			cmd_q    <= req.cmd;
			key_q    <= lane_key;
			handle_q <= req.value_handle;
			count_q  <= req.token_count;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLEAR;
			iss_q      <= '0;
			chk_q      <= '0;
			n_q        <= '0;
			first_q    <= 1'b0;
			step_q     <= 1'b0;
			sum_q      <= '0;
			quo_q      <= '0;
			occupied_q <= '0;
			done_q     <= 1'b0;
			rsp_q      <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_CLEAR: begin
					iss_q <= wrap_inc(iss_q);
					if (iss_q == IDX_W'(SLOTS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (start) begin
						sum_q   <= lane_sum;
						step_q  <= 1'b1;
						state_q <= S_MOD;
					end
				end
				S_MOD: begin
					if (step_q) begin
						quo_q  <= quo_d;
						step_q <= 1'b0;
					end else begin
						iss_q   <= home;
						chk_q   <= home;
						n_q     <= '0;
						first_q <= 1'b1;
						state_q <= S_PROBE;
					end
				end
				S_PROBE: begin
					iss_q   <= wrap_inc(iss_q);
					first_q <= 1'b0;
					if (finish) begin
						occupied_q <= occ_next;
						rsp_q      <= rsp_d;
						done_q     <= 1'b1;
						state_q    <= S_IDLE;
					end else if (chk_valid) begin
						chk_q <= wrap_inc(chk_q);
						n_q   <= n_q + 1'b1;
					end
				end
				default: state_q <= S_CLEAR;
			endcase
		end
	end

	assign busy = state_q != S_IDLE;
	assign done = done_q;
	assign rsp  = rsp_q;

	`CHK_NEXT(a_accept_busy, clk, arst_n, start && !busy, busy, "accepted command did not raise busy")
	`CHK_IMPL(a_done_probe, clk, arst_n, done, $past(state_q == S_PROBE) && !busy, "result strobe outside probe end")
	`CHK_IMPL(a_full_count, clk, arst_n, done && rsp.status == ST_FULL, occupied_q == OCC_W'(SLOTS), "table full reported with free slots")
	`CHK_IMPL(a_insert_fill, clk, arst_n, done && rsp.status == ST_INSERTED, occupied_q == $past(occupied_q) + 1'b1, "insert did not advance the fill count")

endmodule
